// ===== rtl/tirs_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape image record scanner package
// Shared widths, word types, event codes and helper functions.
// ----------------------------------------------------------------------------
package tirs_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FILE_BITS  = 16;

    // Result queue: room for the two words one input byte may raise, plus slack
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    localparam logic [1:0] KIND_RUN       = 2'd0;
    localparam logic [1:0] KIND_FIRST_TM  = 2'd1;
    localparam logic [1:0] KIND_REPEAT_TM = 2'd2;
    localparam logic [1:0] KIND_EOM       = 2'd3;

    localparam logic [15:0] HDR_EOM_MASK = 16'hffff;
    localparam logic [15:0] LEN_ODD_MASK = 16'h0001;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] file_number;
        logic [31:0] first_record;
        logic [31:0] last_record;
        logic [15:0] record_size;
        logic [31:0] record_total;
        logic [31:0] byte_total;
        logic        last_of_step;
    } t_out_item;

    // Words raised by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push_bundle;

    typedef enum logic [10:0] {
        PH_HDR0  = 11'b000_0000_0001,
        PH_HDR1  = 11'b000_0000_0010,
        PH_HDR2  = 11'b000_0000_0100,
        PH_HDR3  = 11'b000_0000_1000,
        PH_DATA  = 11'b000_0001_0000,
        PH_PAD   = 11'b000_0010_0000,
        PH_TRL0  = 11'b000_0100_0000,
        PH_TRL1  = 11'b000_1000_0000,
        PH_TRL2  = 11'b001_0000_0000,
        PH_TRL3  = 11'b010_0000_0000,
        PH_HALT  = 11'b100_0000_0000
    } t_phase;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [31:0] fit32(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    function automatic logic [15:0] fit16(input logic [FILE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

// ===== rtl/tape_image_record_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Tape image record scanner
// Output: a result word is written into the registered result queue and offered from there.
// Throughput: one byte per cycle while the input is not stalled; a byte raises zero, one or two words.
// The input stalls while the four-word result queue holds more than two words.
// Reset: synchronous, active low; clears the scanner state and the queue.
// ----------------------------------------------------------------------------
module tape_image_record_scanner_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tirs_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tirs_pkg::t_out_item o_out
);
    import tirs_pkg::*;

    t_push_bundle push;
    logic         room;
    logic         accept;

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    tirs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .o_push   (push)
    );

    tirs_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/tirs_core.sv =====
// ----------------------------------------------------------------------------
// Tape image record scanner core
// Header/data/pad/trailer sequencing, per-file counters and run grouping.
// ----------------------------------------------------------------------------
module tirs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  tirs_pkg::t_in_item    i_item,
    output tirs_pkg::t_push_bundle o_push
);
    import tirs_pkg::*;

    t_phase                r_phase, n_phase;
    logic [23:0]           r_hdr, n_hdr;
    logic [15:0]           r_left, n_left;
    logic [15:0]           r_seen, n_seen;
    logic [FILE_BITS-1:0]  r_file, n_file;
    logic                  r_mark_seen, n_mark_seen;
    logic [COUNT_BITS-1:0] r_records, n_records;
    logic [COUNT_BITS-1:0] r_run_start, n_run_start;
    logic [15:0]           r_run_len, n_run_len;
    logic                  r_run_open, n_run_open;
    logic [COUNT_BITS-1:0] r_file_bytes, n_file_bytes;
    logic [COUNT_BITS-1:0] r_tape_bytes, n_tape_bytes;

    always_comb begin
        logic        tr_en;
        logic        tm_en;
        logic        eom_en;
        logic [15:0] tr_len;
        logic [31:0] hw;
        logic [1:0]  k;
        t_out_item   items [2];
        t_out_item   w;

        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_left       = r_left;
        n_seen       = r_seen;
        n_file       = r_file;
        n_mark_seen  = r_mark_seen;
        n_records    = r_records;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_run_open   = r_run_open;
        n_file_bytes = r_file_bytes;
        n_tape_bytes = r_tape_bytes;

        tr_en  = 1'b0;
        tm_en  = 1'b0;
        eom_en = 1'b0;
        tr_len = r_seen;
        hw     = {i_item.data_byte, r_hdr};
        k      = 2'd0;
        w      = '0;
        items[0] = '0;
        items[1] = '0;

        // Sequence the phase and decide which events this byte raises
        if (i_accept && r_phase != PH_HALT) begin
            if (i_item.stream_end) begin
                tr_en  = r_phase inside {PH_DATA, PH_PAD, PH_TRL0, PH_TRL1, PH_TRL2,
                                         PH_TRL3};
                tr_len = (r_phase == PH_DATA) ? r_seen - r_left : r_seen;
                eom_en = 1'b1;
            end else begin
                case (r_phase)
                    PH_HDR0: begin
                        n_hdr[7:0] = i_item.data_byte;
                        n_phase    = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_hdr[15:8] = i_item.data_byte;
                        n_phase     = PH_HDR2;
                    end
                    PH_HDR2: begin
                        n_hdr[23:16] = i_item.data_byte;
                        n_phase      = PH_HDR3;
                    end
                    PH_HDR3: begin
                        n_hdr = '0;
                        if ((hw[31:16] & HDR_EOM_MASK) != '0) begin
                            eom_en = 1'b1;
                        end else if (hw[15:0] == '0) begin
                            tm_en   = 1'b1;
                            n_phase = PH_HDR0;
                        end else begin
                            n_seen  = hw[15:0];
                            n_left  = hw[15:0];
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_left = r_left - 16'd1;
                        if (r_left == 16'd1) begin
                            n_phase = ((r_seen & LEN_ODD_MASK) != '0) ? PH_PAD : PH_TRL0;
                        end
                    end
                    PH_PAD:  n_phase = PH_TRL0;
                    PH_TRL0: n_phase = PH_TRL1;
                    PH_TRL1: n_phase = PH_TRL2;
                    PH_TRL2: n_phase = PH_TRL3;
                    PH_TRL3: begin
                        tr_en   = 1'b1;
                        tr_len  = r_seen;
                        n_phase = PH_HDR0;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end

        // Close the open run when the size changes or a file ends
        if ((tr_en && (!r_run_open || tr_len != r_run_len) && r_run_open) ||
            (tm_en && !r_mark_seen && r_run_open)) begin
            w              = '0;
            w.event_kind   = KIND_RUN;
            w.file_number  = fit16(r_file);
            w.first_record = fit32(r_run_start);
            w.last_record  = fit32(r_records);
            w.record_size  = r_run_len;
            items[k[0]]    = w;
            k              = k + 2'd1;
        end

        if (tr_en) begin
            if (!r_run_open || tr_len != r_run_len) begin
                n_run_len   = tr_len;
                n_run_start = sat_add(r_records, COUNT_BITS'(1));
                n_run_open  = 1'b1;
            end
            n_records    = sat_add(r_records, COUNT_BITS'(1));
            n_file_bytes = sat_add(r_file_bytes, COUNT_BITS'(tr_len));
            n_mark_seen  = 1'b0;
        end

        if (tm_en) begin
            w            = '0;
            w.byte_total = fit32(r_file_bytes);
            if (!r_mark_seen) begin
                w.event_kind   = KIND_FIRST_TM;
                w.file_number  = fit16(r_file);
                w.record_total = fit32(r_records);
                if (r_file != {FILE_BITS{1'b1}}) begin
                    n_file = r_file + FILE_BITS'(1);
                end
            end else begin
                w.event_kind  = KIND_REPEAT_TM;
                w.file_number = fit16(r_file - FILE_BITS'(1));
            end
            items[k[0]]  = w;
            k            = k + 2'd1;
            n_mark_seen  = 1'b1;
            n_tape_bytes = sat_add(r_tape_bytes, r_file_bytes);
            n_records    = '0;
            n_run_start  = '0;
            n_file_bytes = '0;
            n_run_open   = 1'b0;
        end

        if (eom_en) begin
            w             = '0;
            w.event_kind  = KIND_EOM;
            w.file_number = fit16(r_file);
            w.byte_total  = fit32(r_tape_bytes);
            items[k[0]]   = w;
            k             = k + 2'd1;
            n_phase       = PH_HALT;
        end

        // Flag the final word of this byte
        if (k == 2'd1) begin
            items[0].last_of_step = 1'b1;
        end else if (k == 2'd2) begin
            items[1].last_of_step = 1'b1;
        end

        o_push.count  = k;
        o_push.first  = items[0];
        o_push.second = items[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_hdr        <= '0;
            r_left       <= '0;
            r_seen       <= '0;
            r_file       <= FILE_BITS'(1);
            r_mark_seen  <= 1'b0;
            r_records    <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_run_open   <= 1'b0;
            r_file_bytes <= '0;
            r_tape_bytes <= '0;
        end else begin
            r_phase      <= n_phase;
            r_hdr        <= n_hdr;
            r_left       <= n_left;
            r_seen       <= n_seen;
            r_file       <= n_file;
            r_mark_seen  <= n_mark_seen;
            r_records    <= n_records;
            r_run_start  <= n_run_start;
            r_run_len    <= n_run_len;
            r_run_open   <= n_run_open;
            r_file_bytes <= n_file_bytes;
            r_tape_bytes <= n_tape_bytes;
        end
    end

endmodule

// ===== rtl/tirs_fifo.sv =====
// ----------------------------------------------------------------------------
// Tape image record scanner result queue
// Takes up to two words per cycle, hands out one word per output handshake.
// ----------------------------------------------------------------------------
module tirs_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tirs_pkg::t_push_bundle i_push,
    output logic                   o_room,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tirs_pkg::t_out_item    o_out
);
    import tirs_pkg::*;

    t_out_item                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic                     pop;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;

    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;
    // Room for a full pair of words whatever the output side does
    assign o_room      = (r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign wr_ptr_next = r_wr_ptr + FIFO_PTR_BITS'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_BITS'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + FIFO_PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_BITS'(i_push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
